// ===== sv/bl2c_pkg.sv =====
// shared types and constants of the band level to rgb color block
`timescale 1ns / 1ps

package bl2c_pkg;

   // bands and field widths
   localparam int NUM_BANDS   = 3;
   localparam int BAND_BASS   = 0;
   localparam int BAND_MID    = 1;
   localparam int BAND_TREBLE = 2;
   localparam int STEP_W      = 10;
   localparam int SCALE_W     = 11;
   localparam int OFFSET_W    = 9;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int BYTE_W      = 8;

   // brightness is q0.16, one more bit to hold exactly 1.0
   localparam int QUOT_W = 16;
   localparam int V_W    = QUOT_W + 1;
   localparam logic [V_W-1:0] V_ONE = V_W'(1) << QUOT_W;

   // divider lanes retire this many quotient bits per cycle
   localparam int BITS_PER_CYCLE = 2;
   localparam int DIV_CYCLES     = QUOT_W / BITS_PER_CYCLE;
   localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

   // hue geometry: six sectors, each sector is 15 * 4 degrees
   localparam int NUM_SECTORS  = 6;
   localparam int SECTOR_MANT  = 15;
   localparam int SECTOR_SHIFT = 2;

   // divide by 15 through a reciprocal, 4369 = floor(2^16 / 15)
   localparam int SCALED_M_W  = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_15 = 13'd4369;

   // register reset values
   localparam logic [STEP_W-1:0] HUE_STEP_RESET = 10'd64;
   localparam logic [NUM_BANDS-1:0][SCALE_W-1:0] SCALE_RESET =
      {11'd256, 11'd282, 11'd13};
   localparam logic [NUM_BANDS-1:0][OFFSET_W-1:0] OFFSET_RESET =
      {9'd77, 9'd77, 9'd77};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HUE_STEP      = 3'd0,
      CSR_BASS_SCALE    = 3'd1,
      CSR_MID_SCALE     = 3'd2,
      CSR_TREBLE_SCALE  = 3'd3,
      CSR_BASS_OFFSET   = 3'd4,
      CSR_MID_OFFSET    = 3'd5,
      CSR_TREBLE_OFFSET = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   // one band as classified by the front: saturated, or numerator below scale
   typedef struct packed {
      logic               sat;
      logic [SCALE_W-1:0] num;
   } lane_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_type;

endpackage

// ===== sv/bl2c_queue.sv =====
// small register queue between the front and the back
`timescale 1ns / 1ps

module bl2c_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/bl2c_front.sv =====
// front end: takes items, advances the hue, splits it into sector and fraction, checks each band against its scale
`timescale 1ns / 1ps

module bl2c_front #(
   parameter int LEVEL_WIDTH   = 16,
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [bl2c_pkg::NUM_BANDS-1:0][LEVEL_WIDTH-1:0] levels,
   input  logic [bl2c_pkg::STEP_W-1:0] hue_step,
   input  logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::SCALE_W-1:0] scale,
   input  logic q_full,
   output logic q_push,
   output bl2c_pkg::lane_type [bl2c_pkg::NUM_BANDS-1:0] lanes,
   output bl2c_pkg::sector_type sector,
   output logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] frac
);

   localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
   localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
   localparam int HUE_W      = $clog2(HUE_FULL);
   localparam int FRAC_W     = $clog2(HUE_SECTOR + 1);
   localparam int SUM_W      = ((HUE_W > bl2c_pkg::STEP_W) ? HUE_W : bl2c_pkg::STEP_W) + 1;
   localparam int WRAP_STEPS = (HUE_FULL - 1 + (2 ** bl2c_pkg::STEP_W) - 1) / HUE_FULL;
   localparam int CMP_W      = (LEVEL_WIDTH > bl2c_pkg::SCALE_W) ? LEVEL_WIDTH
                                                                 : bl2c_pkg::SCALE_W;

   logic             accept;
   logic [HUE_W-1:0] hue_ff, hue_in;
   logic [SUM_W-1:0] hue_sum;
   logic [2:0]       sec_cnt;
   logic [HUE_W-1:0] sec_base;
   logic [HUE_W-1:0] sec_rem;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // hue advance with wrap, a single compare-subtract step
   always_comb begin
      hue_sum = SUM_W'(hue_ff) + SUM_W'(hue_step);
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (hue_sum >= SUM_W'(HUE_FULL)) begin
            hue_sum = hue_sum - SUM_W'(HUE_FULL);
         end
      end
      hue_in = HUE_W'(hue_sum);
   end

   // sector by comparing against the sector boundaries
   always_comb begin
      sec_cnt  = '0;
      sec_base = '0;
      for (int k = 1; k < bl2c_pkg::NUM_SECTORS; k++) begin
         if (hue_in >= HUE_W'(k * HUE_SECTOR)) begin
            sec_cnt  = 3'(k);
            sec_base = HUE_W'(k * HUE_SECTOR);
         end
      end
      sec_rem = hue_in - sec_base;
      sector  = bl2c_pkg::sector_type'(sec_cnt);
      if (sec_cnt[0]) begin
         frac = FRAC_W'(HUE_SECTOR) - FRAC_W'(sec_rem);
      end else begin
         frac = FRAC_W'(sec_rem);
      end
   end

   // level at or above scale, or a zero scale, saturates; otherwise it fits the scale width
   always_comb begin
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         lanes[b].sat = (scale[b] == '0) || (CMP_W'(levels[b]) >= CMP_W'(scale[b]));
         lanes[b].num = bl2c_pkg::SCALE_W'(CMP_W'(levels[b]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= '0;
      end else if (accept) begin
         hue_ff <= hue_in;
      end
   end

endmodule

// ===== sv/bl2c_back.sv =====
// back end: divider lanes, brightness, hsv to rgb and the result register
`timescale 1ns / 1ps

module bl2c_back #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   output logic q_pop,
   input  bl2c_pkg::lane_type [bl2c_pkg::NUM_BANDS-1:0] q_lanes,
   input  bl2c_pkg::sector_type q_sector,
   input  logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] q_frac,
   input  logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::SCALE_W-1:0] scale,
   input  logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::OFFSET_W-1:0] offset,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bl2c_pkg::rgb_type [bl2c_pkg::NUM_BANDS-1:0] rgb
);

   localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
   localparam int FRAC_W     = $clog2(HUE_SECTOR + 1);
   localparam int T_W        = bl2c_pkg::V_W + FRAC_W;
   localparam int N_W        = T_W + 9;
   localparam int C_W        = bl2c_pkg::V_W + 8;
   // 65536 * sector width = 15 << (16 + 2 + frac bits)
   localparam int X_SHIFT    = bl2c_pkg::QUOT_W + bl2c_pkg::SECTOR_SHIFT + HUE_FRAC_BITS;
   localparam longint unsigned ROUND_X = 64'd32768 * HUE_SECTOR;
   localparam longint unsigned ROUND_C = 64'd32768;
   localparam int P_W        = bl2c_pkg::SCALED_M_W + bl2c_pkg::RECIP_W;
   localparam int Q0_W       = P_W - bl2c_pkg::RECIP_SHIFT;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_VAL   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_FIX   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [bl2c_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load;

   logic [bl2c_pkg::NUM_BANDS-1:0]                        sat_ff;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::SCALE_W-1:0] rem_ff, rem_in;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   bl2c_pkg::sector_type                                  sector_ff;
   logic [FRAC_W-1:0]                                     frac_ff;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::V_W-1:0]     v_ff, v_in;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::BYTE_W-1:0]  c_ff, c_in;
   logic [bl2c_pkg::NUM_BANDS-1:0][T_W-1:0]               t_ff, t_in;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::SCALED_M_W-1:0] m_ff, m_in;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::BYTE_W-1:0]  x_ff, x_in;
   bl2c_pkg::rgb_type [bl2c_pkg::NUM_BANDS-1:0]           rgb_ff, rgb_in;

   assign rsp_valid = rsp_valid_ff;
   assign rgb       = rgb_ff;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (!q_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == bl2c_pkg::DIV_CNT_W'(bl2c_pkg::DIV_CYCLES - 1)) begin
               state_in = ST_VAL;
            end
         end
         ST_VAL:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_FIX;
         ST_FIX:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // restoring divide, remainder stays below scale
   always_comb begin
      logic [bl2c_pkg::SCALE_W-1:0] r;
      logic [bl2c_pkg::SCALE_W:0]   r2;
      logic [bl2c_pkg::QUOT_W-1:0]  q;
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         r = rem_ff[b];
         q = quot_ff[b];
         for (int i = 0; i < bl2c_pkg::BITS_PER_CYCLE; i++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, scale[b]}) begin
               r2 = r2 - {1'b0, scale[b]};
               q  = {q[bl2c_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               q  = {q[bl2c_pkg::QUOT_W-2:0], 1'b0};
            end
            r = r2[bl2c_pkg::SCALE_W-1:0];
         end
         rem_in[b]  = r;
         quot_in[b] = q;
      end
   end

   // brightness: clamp, subtract offset, floor at zero
   always_comb begin
      logic [bl2c_pkg::V_W-1:0] scaled;
      logic [bl2c_pkg::V_W-1:0] off;
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         scaled  = sat_ff[b] ? bl2c_pkg::V_ONE : {1'b0, quot_ff[b]};
         off     = {offset[b], 8'b0};
         v_in[b] = (scaled > off) ? scaled - off : '0;
      end
   end

   // primary component round(v * 255) and the product v * fraction
   always_comb begin
      logic [C_W-1:0] cw;
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         cw      = (C_W'(v_ff[b]) << 8) - C_W'(v_ff[b]) + C_W'(ROUND_C);
         c_in[b] = cw[bl2c_pkg::QUOT_W +: bl2c_pkg::BYTE_W];
         t_in[b] = T_W'(v_ff[b]) * T_W'(frac_ff);
      end
   end

   // numerator t * 255 plus half, the power of two part of the divisor shifted out
   always_comb begin
      logic [N_W-1:0] n;
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         n       = (N_W'(t_ff[b]) << 8) - N_W'(t_ff[b]) + N_W'(ROUND_X);
         m_in[b] = bl2c_pkg::SCALED_M_W'(n >> X_SHIFT);
      end
   end

   // remaining divide by 15: reciprocal estimate, one correction step
   always_comb begin
      logic [P_W-1:0]                   p;
      logic [Q0_W-1:0]                  q0;
      logic [bl2c_pkg::SCALED_M_W-1:0] r;
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         p  = P_W'(m_ff[b]) * P_W'(bl2c_pkg::RECIP_15);
         q0 = p[bl2c_pkg::RECIP_SHIFT +: Q0_W];
         r  = m_ff[b] - (bl2c_pkg::SCALED_M_W'(q0) * bl2c_pkg::SCALED_M_W'(bl2c_pkg::SECTOR_MANT));
         if (r >= bl2c_pkg::SCALED_M_W'(bl2c_pkg::SECTOR_MANT)) begin
            x_in[b] = bl2c_pkg::BYTE_W'(q0) + 1'b1;
         end else begin
            x_in[b] = bl2c_pkg::BYTE_W'(q0);
         end
      end
   end

   // six-sector placement of primary and secondary components
   always_comb begin
      for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
         unique case (sector_ff)
            bl2c_pkg::SEC_RED_YELLOW:   rgb_in[b] = '{red: c_ff[b], green: x_ff[b], blue: '0};
            bl2c_pkg::SEC_YELLOW_GREEN: rgb_in[b] = '{red: x_ff[b], green: c_ff[b], blue: '0};
            bl2c_pkg::SEC_GREEN_CYAN:   rgb_in[b] = '{red: '0, green: c_ff[b], blue: x_ff[b]};
            bl2c_pkg::SEC_CYAN_BLUE:    rgb_in[b] = '{red: '0, green: x_ff[b], blue: c_ff[b]};
            bl2c_pkg::SEC_BLUE_MAGENTA: rgb_in[b] = '{red: x_ff[b], green: '0, blue: c_ff[b]};
            bl2c_pkg::SEC_MAGENTA_RED:  rgb_in[b] = '{red: c_ff[b], green: '0, blue: x_ff[b]};
            default:                    rgb_in[b] = '{red: c_ff[b], green: '0, blue: x_ff[b]};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         sector_ff <= q_sector;
         frac_ff   <= q_frac;
         for (int b = 0; b < bl2c_pkg::NUM_BANDS; b++) begin
            sat_ff[b]  <= q_lanes[b].sat;
            rem_ff[b]  <= q_lanes[b].num;
            quot_ff[b] <= '0;
         end
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (state_ff == ST_VAL) begin
         v_ff <= v_in;
      end
      if (state_ff == ST_MUL) begin
         c_ff <= c_in;
         t_ff <= t_in;
      end
      if (state_ff == ST_SCALE) begin
         m_ff <= m_in;
      end
      if (state_ff == ST_FIX) begin
         x_ff <= x_in;
      end
      if (out_load) begin
         rgb_ff <= rgb_in;
      end
   end

endmodule

// ===== sv/band_level_to_rgb_color.sv =====
// top level of the band level to rgb color block
// an accepted item passes the queue, then the back end sequence, to rsp_valid
// the back end works on one item at a time, through its idle step, the three
//   radix-4 divider lanes, 4 arithmetic steps and the result step
// a 2-deep queue lets the front keep taking items while a result waits
// reset is synchronous: hue goes to 0, registers to defaults, queue and result empty
`timescale 1ns / 1ps

module band_level_to_rgb_color #(
   parameter int LEVEL_WIDTH   = 16,
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic clock,
   input  logic reset,

   // input items: three band energies, q8.8
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEVEL_WIDTH-1:0] req_bass_level,
   input  logic [LEVEL_WIDTH-1:0] req_mid_level,
   input  logic [LEVEL_WIDTH-1:0] req_treble_level,

   // result items: one rgb triple per band
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_bass_red,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_bass_green,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_bass_blue,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_mid_red,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_mid_green,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_mid_blue,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_treble_red,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_treble_green,
   output logic [bl2c_pkg::BYTE_W-1:0]   rsp_treble_blue,

   // register writes
   input  logic                            csr_wr_en,
   input  logic [bl2c_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bl2c_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FRAC_W  = $clog2((60 << HUE_FRAC_BITS) + 1);
   localparam int LANES_W = bl2c_pkg::NUM_BANDS * $bits(bl2c_pkg::lane_type);
   localparam int SEC_W   = $bits(bl2c_pkg::sector_type);
   localparam int ENTRY_W = LANES_W + SEC_W + FRAC_W;
   localparam int Q_DEPTH = 2;

   // configuration registers
   logic [bl2c_pkg::STEP_W-1:0] hue_step_ff;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::SCALE_W-1:0]  scale_ff;
   logic [bl2c_pkg::NUM_BANDS-1:0][bl2c_pkg::OFFSET_W-1:0] offset_ff;

   // front to queue
   logic [bl2c_pkg::NUM_BANDS-1:0][LEVEL_WIDTH-1:0]  levels;
   bl2c_pkg::lane_type [bl2c_pkg::NUM_BANDS-1:0]     front_lanes;
   bl2c_pkg::sector_type                             front_sector;
   logic [FRAC_W-1:0]                                front_frac;
   logic                                             q_push;
   logic                                             q_full;
   logic [ENTRY_W-1:0]                               q_push_data;

   // queue to back
   logic                                             q_pop;
   logic                                             q_empty;
   logic [ENTRY_W-1:0]                               q_pop_data;
   bl2c_pkg::lane_type [bl2c_pkg::NUM_BANDS-1:0]     back_lanes;
   bl2c_pkg::sector_type                             back_sector;
   logic [FRAC_W-1:0]                                back_frac;

   bl2c_pkg::rgb_type [bl2c_pkg::NUM_BANDS-1:0]      rgb;

   // register writes, unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_step_ff <= bl2c_pkg::HUE_STEP_RESET;
         scale_ff    <= bl2c_pkg::SCALE_RESET;
         offset_ff   <= bl2c_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         unique case (bl2c_pkg::csr_index_type'(csr_index))
            bl2c_pkg::CSR_HUE_STEP:
               hue_step_ff <= csr_wdata[bl2c_pkg::STEP_W-1:0];
            bl2c_pkg::CSR_BASS_SCALE:
               scale_ff[bl2c_pkg::BAND_BASS] <= csr_wdata[bl2c_pkg::SCALE_W-1:0];
            bl2c_pkg::CSR_MID_SCALE:
               scale_ff[bl2c_pkg::BAND_MID] <= csr_wdata[bl2c_pkg::SCALE_W-1:0];
            bl2c_pkg::CSR_TREBLE_SCALE:
               scale_ff[bl2c_pkg::BAND_TREBLE] <= csr_wdata[bl2c_pkg::SCALE_W-1:0];
            bl2c_pkg::CSR_BASS_OFFSET:
               offset_ff[bl2c_pkg::BAND_BASS] <= csr_wdata[bl2c_pkg::OFFSET_W-1:0];
            bl2c_pkg::CSR_MID_OFFSET:
               offset_ff[bl2c_pkg::BAND_MID] <= csr_wdata[bl2c_pkg::OFFSET_W-1:0];
            bl2c_pkg::CSR_TREBLE_OFFSET:
               offset_ff[bl2c_pkg::BAND_TREBLE] <= csr_wdata[bl2c_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   assign levels[bl2c_pkg::BAND_BASS]   = req_bass_level;
   assign levels[bl2c_pkg::BAND_MID]    = req_mid_level;
   assign levels[bl2c_pkg::BAND_TREBLE] = req_treble_level;

   // front: hue advance and per-band saturation check
   bl2c_front #(
      .LEVEL_WIDTH   (LEVEL_WIDTH),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .levels    (levels),
      .hue_step  (hue_step_ff),
      .scale     (scale_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .lanes     (front_lanes),
      .sector    (front_sector),
      .frac      (front_frac)
   );

   assign q_push_data = {front_lanes, front_sector, front_frac};

   // queue decouples the front from the long back-end sequence
   bl2c_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {back_lanes, back_sector, back_frac} = q_pop_data;

   // back: divide, brightness, color, result register
   bl2c_back #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_lanes   (back_lanes),
      .q_sector  (back_sector),
      .q_frac    (back_frac),
      .scale     (scale_ff),
      .offset    (offset_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rgb       (rgb)
   );

   assign rsp_bass_red     = rgb[bl2c_pkg::BAND_BASS].red;
   assign rsp_bass_green   = rgb[bl2c_pkg::BAND_BASS].green;
   assign rsp_bass_blue    = rgb[bl2c_pkg::BAND_BASS].blue;
   assign rsp_mid_red      = rgb[bl2c_pkg::BAND_MID].red;
   assign rsp_mid_green    = rgb[bl2c_pkg::BAND_MID].green;
   assign rsp_mid_blue     = rgb[bl2c_pkg::BAND_MID].blue;
   assign rsp_treble_red   = rgb[bl2c_pkg::BAND_TREBLE].red;
   assign rsp_treble_green = rgb[bl2c_pkg::BAND_TREBLE].green;
   assign rsp_treble_blue  = rgb[bl2c_pkg::BAND_TREBLE].blue;

endmodule

// ===== sv/bl2c_checker.sv =====
// port-level checks for the band level to rgb color block, bound to the top level
`timescale 1ns / 1ps

module bl2c_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_bass_red,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_bass_green,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_bass_blue,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_mid_red,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_mid_green,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_mid_blue,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_treble_red,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_treble_green,
   input logic [bl2c_pkg::BYTE_W-1:0] rsp_treble_blue
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bass_red)
         && $stable(rsp_bass_green) && $stable(rsp_bass_blue)
         && $stable(rsp_mid_red) && $stable(rsp_mid_green) && $stable(rsp_mid_blue)
         && $stable(rsp_treble_red) && $stable(rsp_treble_green)
         && $stable(rsp_treble_blue))
      else $error("result changed while stalled");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the divider sequence lies between reset and a rising result
   a_rsp_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result too soon after reset");

   // full saturation: every color has one component at zero
   a_full_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_bass_red == '0 || rsp_bass_green == '0 || rsp_bass_blue == '0)
         && (rsp_mid_red == '0 || rsp_mid_green == '0 || rsp_mid_blue == '0)
         && (rsp_treble_red == '0 || rsp_treble_green == '0 || rsp_treble_blue == '0))
      else $error("color without a zero component");

endmodule

bind band_level_to_rgb_color bl2c_checker u_bl2c_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_bass_red     (rsp_bass_red),
   .rsp_bass_green   (rsp_bass_green),
   .rsp_bass_blue    (rsp_bass_blue),
   .rsp_mid_red      (rsp_mid_red),
   .rsp_mid_green    (rsp_mid_green),
   .rsp_mid_blue     (rsp_mid_blue),
   .rsp_treble_red   (rsp_treble_red),
   .rsp_treble_green (rsp_treble_green),
   .rsp_treble_blue  (rsp_treble_blue)
);
